[rtl/ocu_pkg.sv]
package ocu_pkg;

   localparam int FRAC_BITS         = 16;
   localparam int CORDIC_ITERATIONS = 24;
   localparam int ANG_FRAC          = 30;
   localparam int ANG_SHIFT         = ANG_FRAC - FRAC_BITS;

   localparam int FIELD_W    = 32;
   localparam int SAT_W      = 64;
   localparam int CORDIC_W   = 38;
   localparam int REM_W      = 34;
   localparam int ANGLE_W    = REM_W + 1;
   localparam int TURN_W     = 48;
   localparam int TURN_CNT_W = $clog2(TURN_W + 1);
   localparam int ITER_W     = $clog2(CORDIC_ITERATIONS + 1);
   localparam int MUL_W      = 40;
   localparam int MUL_DIGIT  = 4;
   localparam int MUL_STEPS  = MUL_W / MUL_DIGIT;
   localparam int MUL_CNT_W  = $clog2(MUL_STEPS + 1);
   localparam int TERM_W     = 2 * FIELD_W - FRAC_BITS;

   localparam logic signed [ANGLE_W-1:0] PI_Q30      = ANGLE_W'(64'sd3373259426);
   localparam logic signed [ANGLE_W-1:0] HALF_PI_Q30 = ANGLE_W'(64'sd1686629713);
   localparam logic signed [ANGLE_W-1:0] TWO_PI_Q30  = ANGLE_W'(64'sd6746518852);
   localparam logic signed [MUL_W-1:0]   INV_GAIN_Q30 = MUL_W'(64'sd652032875);

   localparam logic signed [SAT_W-1:0] FIELD_MAX = SAT_W'((64'sd1 <<< (FIELD_W - 1)) - 64'sd1);
   localparam logic signed [SAT_W-1:0] FIELD_MIN = -FIELD_MAX - SAT_W'(1);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIFF,
      ST_VEC,
      ST_MUL,
      ST_MOD_LOAD,
      ST_MOD,
      ST_FOLD,
      ST_ROT,
      ST_SUM_POS,
      ST_SUM_FOCUS,
      ST_DONE
   } ocu_state_type;

   typedef enum logic [3:0] {
      MUL_RHO,
      MUL_RMAG,
      MUL_RS,
      MUL_FOC_X,
      MUL_FOC_Y,
      MUL_FOC_Z,
      MUL_FWD_X,
      MUL_SIDE_X,
      MUL_FWD_Y,
      MUL_FWD_Z,
      MUL_SIDE_Z
   } mul_op_type;

   typedef struct packed {
      logic start;
      logic vectoring;
   } cordic_cmd_type;

   function automatic logic signed [ANGLE_W-1:0] atan_q30(input logic [4:0] i);
      logic signed [ANGLE_W-1:0] a;
      case (i)
         5'd0:  a = ANGLE_W'(64'sd843314857);
         5'd1:  a = ANGLE_W'(64'sd497837830);
         5'd2:  a = ANGLE_W'(64'sd263043837);
         5'd3:  a = ANGLE_W'(64'sd133525159);
         5'd4:  a = ANGLE_W'(64'sd67021687);
         5'd5:  a = ANGLE_W'(64'sd33543516);
         5'd6:  a = ANGLE_W'(64'sd16775851);
         5'd7:  a = ANGLE_W'(64'sd8388437);
         5'd8:  a = ANGLE_W'(64'sd4194283);
         5'd9:  a = ANGLE_W'(64'sd2097149);
         5'd10: a = ANGLE_W'(64'sd1048576);
         5'd11: a = ANGLE_W'(64'sd524288);
         5'd12: a = ANGLE_W'(64'sd262144);
         5'd13: a = ANGLE_W'(64'sd131072);
         5'd14: a = ANGLE_W'(64'sd65536);
         5'd15: a = ANGLE_W'(64'sd32768);
         5'd16: a = ANGLE_W'(64'sd16384);
         5'd17: a = ANGLE_W'(64'sd8192);
         5'd18: a = ANGLE_W'(64'sd4096);
         5'd19: a = ANGLE_W'(64'sd2048);
         5'd20: a = ANGLE_W'(64'sd1024);
         5'd21: a = ANGLE_W'(64'sd512);
         5'd22: a = ANGLE_W'(64'sd256);
         5'd23: a = ANGLE_W'(64'sd128);
         5'd24: a = ANGLE_W'(64'sd64);
         5'd25: a = ANGLE_W'(64'sd32);
         5'd26: a = ANGLE_W'(64'sd16);
         5'd27: a = ANGLE_W'(64'sd8);
         5'd28: a = ANGLE_W'(64'sd4);
         5'd29: a = ANGLE_W'(64'sd2);
         5'd30: a = ANGLE_W'(64'sd1);
         default: a = '0;
      endcase
      return a;
   endfunction

   function automatic logic signed [FIELD_W-1:0] sat_field(input logic signed [SAT_W-1:0] v);
      logic signed [FIELD_W-1:0] r;
      if (v > FIELD_MAX) begin
         r = FIELD_W'(FIELD_MAX);
      end else if (v < FIELD_MIN) begin
         r = FIELD_W'(FIELD_MIN);
      end else begin
         r = FIELD_W'(v);
      end
      return r;
   endfunction

endpackage

[rtl/orbit_camera_update.sv]
// Orbit camera update. Each request beat carries a camera (position, focus, fov, signed
// Q16.16) and this frame's pan, look and fov deltas; one response beat comes back per request.
// With camera_enable low, or on the first enabled frame, the camera passes through unchanged
// and passed_through is 1. Otherwise the block rotates the focus-minus-position vector by yaw
// and pitch in spherical coordinates, moves the position along the view and side vectors and
// returns the kept camera. Such an item is worked through in two 48-step bit-serial angle
// reductions, four 24-step CORDIC passes on one shared unit and eleven 10-digit multiplies on
// one shared radix-16 multiplier. One item is in work at a time; a finished response waits in
// its output register while the next request is taken.
module orbit_camera_update (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic               csr_wr_data,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_in_pos_x,
   input  logic signed [31:0] req_in_pos_y,
   input  logic signed [31:0] req_in_pos_z,
   input  logic signed [31:0] req_in_focus_x,
   input  logic signed [31:0] req_in_focus_y,
   input  logic signed [31:0] req_in_focus_z,
   input  logic signed [31:0] req_in_fov,
   input  logic signed [31:0] req_pan_side,
   input  logic signed [31:0] req_pan_forward,
   input  logic signed [31:0] req_look_yaw,
   input  logic signed [31:0] req_look_pitch,
   input  logic signed [31:0] req_fov_offset,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_out_pos_x,
   output logic signed [31:0] rsp_out_pos_y,
   output logic signed [31:0] rsp_out_pos_z,
   output logic signed [31:0] rsp_out_focus_x,
   output logic signed [31:0] rsp_out_focus_y,
   output logic signed [31:0] rsp_out_focus_z,
   output logic signed [31:0] rsp_out_fov,
   output logic               rsp_passed_through
);

   localparam int FW = ocu_pkg::FIELD_W;
   localparam int SW = ocu_pkg::SAT_W;
   localparam int MW = ocu_pkg::MUL_W;
   localparam int CW = ocu_pkg::CORDIC_W;
   localparam int AW = ocu_pkg::ANGLE_W;
   localparam int TW = ocu_pkg::TURN_W;
   localparam int RW = ocu_pkg::REM_W;
   localparam int EW = ocu_pkg::TERM_W;

   ocu_pkg::ocu_state_type  state_ff;
   ocu_pkg::ocu_state_type  state_in;
   ocu_pkg::mul_op_type     mul_op_ff;
   ocu_pkg::cordic_cmd_type cordic_cmd;

   logic enable_ff;
   logic captured_ff;
   logic recap_ff;
   logic pass_ff;
   logic which_ff;
   logic started_ff;
   logic rsp_valid_ff;

   logic signed [FW-1:0] spos_ff [3];
   logic signed [FW-1:0] sfoc_ff [3];
   logic signed [FW-1:0] sfov_ff;
   logic signed [FW-1:0] ipos_ff [3];
   logic signed [FW-1:0] ifoc_ff [3];
   logic signed [FW-1:0] ifov_ff;
   logic signed [FW-1:0] side_ff;
   logic signed [FW-1:0] fwd_ff;
   logic signed [FW-1:0] yaw_ff;
   logic signed [FW-1:0] pitch_ff;
   logic signed [FW-1:0] fovofs_ff;
   logic signed [FW-1:0] r_ff [3];
   logic signed [FW-1:0] fov_res_ff;

   logic signed [CW-1:0] xm_ff;
   logic signed [AW-1:0] theta_ff;
   logic signed [AW-1:0] phi_ff;
   logic signed [MW-1:0] rho_ff;
   logic signed [MW-1:0] rmag_ff;
   logic signed [MW-1:0] rs_ff;
   logic signed [MW-1:0] ct_ff;
   logic signed [MW-1:0] st_ff;
   logic signed [MW-1:0] cp_ff;
   logic signed [MW-1:0] sp_ff;
   logic signed [MW-1:0] fx_ff;
   logic signed [MW-1:0] fy_ff;
   logic signed [MW-1:0] fz_ff;
   logic signed [EW-1:0] fwd_x_ff;
   logic signed [EW-1:0] side_x_ff;
   logic signed [EW-1:0] fwd_y_ff;
   logic signed [EW-1:0] fwd_z_ff;
   logic signed [EW-1:0] side_z_ff;

   logic                         tneg_ff;
   logic [TW-1:0]                tshift_ff;
   logic [RW-1:0]                rem_ff;
   logic [ocu_pkg::TURN_CNT_W-1:0] tcnt_ff;
   logic signed [AW-1:0]         rot_z_ff;
   logic                         rot_neg_ff;

   logic signed [FW-1:0] rsp_pos_ff [3];
   logic signed [FW-1:0] rsp_foc_ff [3];
   logic signed [FW-1:0] rsp_fov_ff;
   logic                 rsp_pass_ff;

   logic                 accept;
   logic                 rsp_free;
   logic                 mul_start;
   logic                 mul_done;
   logic signed [MW-1:0] mul_a;
   logic signed [MW-1:0] mul_b;
   logic signed [2*MW-1:0] mul_prod;
   logic signed [MW-1:0] ang_prod;
   logic signed [EW-1:0] q_prod;
   logic                 cordic_done;
   logic signed [CW-1:0] cordic_x_in;
   logic signed [CW-1:0] cordic_y_in;
   logic signed [CW-1:0] cordic_x;
   logic signed [CW-1:0] cordic_y;
   logic signed [AW-1:0] cordic_z;
   logic signed [MW-1:0] rot_c;
   logic signed [MW-1:0] rot_s;
   logic signed [TW-1:0] turn;
   logic [RW-1:0]        rem_sh;
   logic signed [AW-1:0] tm;
   logic signed [AW-1:0] t1;
   logic signed [AW-1:0] t2;
   logic                 fold_neg;

   assign accept   = req_valid && req_ready;
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ocu_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in             = state_ff;
      req_ready            = (state_ff == ocu_pkg::ST_IDLE);
      cordic_cmd.start     = 1'b0;
      cordic_cmd.vectoring = 1'b0;
      mul_start            = 1'b0;
      unique case (state_ff)
         ocu_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = (enable_ff && captured_ff) ? ocu_pkg::ST_DIFF : ocu_pkg::ST_DONE;
            end
         end
         ocu_pkg::ST_DIFF: state_in = ocu_pkg::ST_VEC;
         ocu_pkg::ST_VEC: begin
            cordic_cmd.start     = !started_ff;
            cordic_cmd.vectoring = 1'b1;
            if (cordic_done) begin
               state_in = ocu_pkg::ST_MUL;
            end
         end
         ocu_pkg::ST_MUL: begin
            mul_start = !started_ff;
            if (mul_done) begin
               case (mul_op_ff)
                  ocu_pkg::MUL_RHO:    state_in = ocu_pkg::ST_VEC;
                  ocu_pkg::MUL_RMAG:   state_in = ocu_pkg::ST_MOD_LOAD;
                  ocu_pkg::MUL_SIDE_Z: state_in = ocu_pkg::ST_SUM_POS;
                  default:             state_in = ocu_pkg::ST_MUL;
               endcase
            end
         end
         ocu_pkg::ST_MOD_LOAD: state_in = ocu_pkg::ST_MOD;
         ocu_pkg::ST_MOD: begin
            if (tcnt_ff == ocu_pkg::TURN_CNT_W'(TW - 1)) begin
               state_in = ocu_pkg::ST_FOLD;
            end
         end
         ocu_pkg::ST_FOLD: state_in = ocu_pkg::ST_ROT;
         ocu_pkg::ST_ROT: begin
            cordic_cmd.start = !started_ff;
            if (cordic_done) begin
               state_in = which_ff ? ocu_pkg::ST_MUL : ocu_pkg::ST_MOD_LOAD;
            end
         end
         ocu_pkg::ST_SUM_POS:   state_in = ocu_pkg::ST_SUM_FOCUS;
         ocu_pkg::ST_SUM_FOCUS: state_in = ocu_pkg::ST_DONE;
         ocu_pkg::ST_DONE: begin
            if (rsp_free) begin
               state_in = ocu_pkg::ST_IDLE;
            end
         end
         default: state_in = ocu_pkg::ST_IDLE;
      endcase
   end

   // shared multiplier operands
   always_comb begin
      case (mul_op_ff) inside
         ocu_pkg::MUL_RHO, ocu_pkg::MUL_RMAG: begin
            mul_a = MW'(xm_ff);
            mul_b = ocu_pkg::INV_GAIN_Q30;
         end
         ocu_pkg::MUL_RS:     begin mul_a = rmag_ff;      mul_b = sp_ff;      end
         ocu_pkg::MUL_FOC_X:  begin mul_a = rs_ff;        mul_b = ct_ff;      end
         ocu_pkg::MUL_FOC_Y:  begin mul_a = rmag_ff;      mul_b = cp_ff;      end
         ocu_pkg::MUL_FOC_Z:  begin mul_a = rs_ff;        mul_b = st_ff;      end
         ocu_pkg::MUL_FWD_X:  begin mul_a = MW'(r_ff[0]); mul_b = MW'(fwd_ff);  end
         ocu_pkg::MUL_SIDE_X: begin mul_a = MW'(side_ff); mul_b = MW'(r_ff[2]); end
         ocu_pkg::MUL_FWD_Y:  begin mul_a = MW'(r_ff[1]); mul_b = MW'(fwd_ff);  end
         ocu_pkg::MUL_FWD_Z:  begin mul_a = MW'(r_ff[2]); mul_b = MW'(fwd_ff);  end
         ocu_pkg::MUL_SIDE_Z: begin mul_a = MW'(side_ff); mul_b = MW'(r_ff[0]); end
         default:             begin mul_a = '0;           mul_b = '0;         end
      endcase
   end

   assign ang_prod = MW'(mul_prod >>> ocu_pkg::ANG_FRAC);
   assign q_prod   = EW'(mul_prod >>> ocu_pkg::FRAC_BITS);

   assign cordic_x_in = (state_ff == ocu_pkg::ST_VEC) ?
                        (which_ff ? CW'(r_ff[1]) : CW'(r_ff[0])) : CW'(ocu_pkg::INV_GAIN_Q30);
   assign cordic_y_in = (state_ff == ocu_pkg::ST_VEC) ?
                        (which_ff ? CW'(rho_ff) : CW'(r_ff[2])) : '0;

   assign rot_c = rot_neg_ff ? -MW'(cordic_x) : MW'(cordic_x);
   assign rot_s = rot_neg_ff ? -MW'(cordic_y) : MW'(cordic_y);

   // angle plus the frame's delta, scaled up to the internal angle format
   assign turn = which_ff ? (TW'(phi_ff) + (TW'(pitch_ff) <<< ocu_pkg::ANG_SHIFT))
                          : (TW'(theta_ff) + (TW'(yaw_ff) <<< ocu_pkg::ANG_SHIFT));
   assign rem_sh = {rem_ff[RW-2:0], tshift_ff[TW-1]};

   // wrap into [-pi, pi], then fold into [-pi/2, pi/2]
   always_comb begin
      tm = tneg_ff ? -$signed({1'b0, rem_ff}) : $signed({1'b0, rem_ff});
      if (tm > ocu_pkg::PI_Q30) begin
         t1 = tm - ocu_pkg::TWO_PI_Q30;
      end else if (tm < -ocu_pkg::PI_Q30) begin
         t1 = tm + ocu_pkg::TWO_PI_Q30;
      end else begin
         t1 = tm;
      end
      fold_neg = 1'b0;
      if (t1 > ocu_pkg::HALF_PI_Q30) begin
         t2       = t1 - ocu_pkg::PI_Q30;
         fold_neg = 1'b1;
      end else if (t1 < -ocu_pkg::HALF_PI_Q30) begin
         t2       = t1 + ocu_pkg::PI_Q30;
         fold_neg = 1'b1;
      end else begin
         t2 = t1;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= 1'b0;
         captured_ff  <= 1'b0;
         recap_ff     <= 1'b0;
         which_ff     <= 1'b0;
         started_ff   <= 1'b0;
         mul_op_ff    <= ocu_pkg::MUL_RHO;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < 3; k++) begin
            spos_ff[k] <= '0;
            sfoc_ff[k] <= '0;
         end
         sfov_ff <= '0;
      end else begin
         if (cordic_done || mul_done) begin
            started_ff <= 1'b0;
         end else if (cordic_cmd.start || mul_start) begin
            started_ff <= 1'b1;
         end

         if (accept) begin
            which_ff  <= 1'b0;
            mul_op_ff <= ocu_pkg::MUL_RHO;
            if (!enable_ff) begin
               captured_ff <= 1'b0;
               recap_ff    <= 1'b0;
               for (int k = 0; k < 3; k++) begin
                  spos_ff[k] <= '0;
                  sfoc_ff[k] <= '0;
               end
               sfov_ff <= '0;
            end else if (!captured_ff || recap_ff) begin
               captured_ff <= 1'b1;
               recap_ff    <= !captured_ff;
               spos_ff[0]  <= req_in_pos_x;
               spos_ff[1]  <= req_in_pos_y;
               spos_ff[2]  <= req_in_pos_z;
               sfoc_ff[0]  <= req_in_focus_x;
               sfoc_ff[1]  <= req_in_focus_y;
               sfoc_ff[2]  <= req_in_focus_z;
               sfov_ff     <= req_in_fov;
            end
         end

         if (mul_done) begin
            if (mul_op_ff == ocu_pkg::MUL_RHO) begin
               which_ff <= 1'b1;
            end else if (mul_op_ff == ocu_pkg::MUL_RMAG) begin
               which_ff <= 1'b0;
            end
            if (mul_op_ff != ocu_pkg::MUL_SIDE_Z) begin
               mul_op_ff <= ocu_pkg::mul_op_type'(mul_op_ff + 1'b1);
            end
         end
         if (state_ff == ocu_pkg::ST_ROT && cordic_done) begin
            which_ff <= 1'b1;
         end

         if (state_ff == ocu_pkg::ST_SUM_POS) begin
            spos_ff[0] <= ocu_pkg::sat_field(SW'(spos_ff[0]) + SW'(fwd_x_ff) + SW'(side_x_ff));
            spos_ff[1] <= ocu_pkg::sat_field(SW'(spos_ff[1]) + SW'(fwd_y_ff));
            spos_ff[2] <= ocu_pkg::sat_field(SW'(spos_ff[2]) + SW'(fwd_z_ff) - SW'(side_z_ff));
         end
         if (state_ff == ocu_pkg::ST_SUM_FOCUS) begin
            sfoc_ff[0] <= ocu_pkg::sat_field(SW'(spos_ff[0]) + SW'(fx_ff));
            sfoc_ff[1] <= ocu_pkg::sat_field(SW'(spos_ff[1]) + SW'(fy_ff));
            sfoc_ff[2] <= ocu_pkg::sat_field(SW'(spos_ff[2]) + SW'(fz_ff));
         end

         if (state_ff == ocu_pkg::ST_DONE && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         if (csr_wr_en) begin
            enable_ff <= csr_wr_data;
            if (!csr_wr_data) begin
               captured_ff <= 1'b0;
               recap_ff    <= 1'b0;
               for (int k = 0; k < 3; k++) begin
                  spos_ff[k] <= '0;
                  sfoc_ff[k] <= '0;
               end
               sfov_ff <= '0;
            end
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (accept) begin
         ipos_ff[0] <= req_in_pos_x;
         ipos_ff[1] <= req_in_pos_y;
         ipos_ff[2] <= req_in_pos_z;
         ifoc_ff[0] <= req_in_focus_x;
         ifoc_ff[1] <= req_in_focus_y;
         ifoc_ff[2] <= req_in_focus_z;
         ifov_ff    <= req_in_fov;
         side_ff    <= req_pan_side;
         fwd_ff     <= req_pan_forward;
         yaw_ff     <= req_look_yaw;
         pitch_ff   <= req_look_pitch;
         fovofs_ff  <= req_fov_offset;
         pass_ff    <= !(enable_ff && captured_ff);
      end

      if (state_ff == ocu_pkg::ST_DIFF) begin
         for (int k = 0; k < 3; k++) begin
            r_ff[k] <= ocu_pkg::sat_field(SW'(sfoc_ff[k]) - SW'(spos_ff[k]));
         end
      end

      if (state_ff == ocu_pkg::ST_VEC && cordic_done) begin
         xm_ff <= cordic_x;
         if (which_ff) begin
            phi_ff <= cordic_z;
         end else begin
            theta_ff <= cordic_z;
         end
      end

      if (mul_done) begin
         case (mul_op_ff)
            ocu_pkg::MUL_RHO:    rho_ff    <= ang_prod;
            ocu_pkg::MUL_RMAG:   rmag_ff   <= ang_prod;
            ocu_pkg::MUL_RS:     rs_ff     <= ang_prod;
            ocu_pkg::MUL_FOC_X:  fx_ff     <= ang_prod;
            ocu_pkg::MUL_FOC_Y:  fy_ff     <= ang_prod;
            ocu_pkg::MUL_FOC_Z:  fz_ff     <= ang_prod;
            ocu_pkg::MUL_FWD_X:  fwd_x_ff  <= q_prod;
            ocu_pkg::MUL_SIDE_X: side_x_ff <= q_prod;
            ocu_pkg::MUL_FWD_Y:  fwd_y_ff  <= q_prod;
            ocu_pkg::MUL_FWD_Z:  fwd_z_ff  <= q_prod;
            ocu_pkg::MUL_SIDE_Z: side_z_ff <= q_prod;
            default:             rho_ff    <= rho_ff;
         endcase
      end

      // magnitude reduction modulo two pi, one bit per cycle
      if (state_ff == ocu_pkg::ST_MOD_LOAD) begin
         tneg_ff   <= turn[TW-1];
         tshift_ff <= turn[TW-1] ? (~$unsigned(turn)) + 1'b1 : $unsigned(turn);
         rem_ff    <= '0;
         tcnt_ff   <= '0;
      end else if (state_ff == ocu_pkg::ST_MOD) begin
         rem_ff    <= (rem_sh >= RW'(ocu_pkg::TWO_PI_Q30)) ?
                      rem_sh - RW'(ocu_pkg::TWO_PI_Q30) : rem_sh;
         tshift_ff <= tshift_ff << 1;
         tcnt_ff   <= tcnt_ff + 1'b1;
      end

      if (state_ff == ocu_pkg::ST_FOLD) begin
         rot_z_ff   <= t2;
         rot_neg_ff <= fold_neg;
      end

      if (state_ff == ocu_pkg::ST_ROT && cordic_done) begin
         if (which_ff) begin
            cp_ff <= rot_c;
            sp_ff <= rot_s;
         end else begin
            ct_ff <= rot_c;
            st_ff <= rot_s;
         end
      end

      if (state_ff == ocu_pkg::ST_SUM_POS) begin
         fov_res_ff <= ocu_pkg::sat_field(SW'(sfov_ff) + SW'(fovofs_ff));
      end

      if (state_ff == ocu_pkg::ST_DONE && rsp_free) begin
         for (int k = 0; k < 3; k++) begin
            rsp_pos_ff[k] <= pass_ff ? ipos_ff[k] : spos_ff[k];
            rsp_foc_ff[k] <= pass_ff ? ifoc_ff[k] : sfoc_ff[k];
         end
         rsp_fov_ff  <= pass_ff ? ifov_ff : fov_res_ff;
         rsp_pass_ff <= pass_ff;
      end
   end

   ocu_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .cmd   (cordic_cmd),
      .x_in  (cordic_x_in),
      .y_in  (cordic_y_in),
      .z_in  (rot_z_ff),
      .done  (cordic_done),
      .x_out (cordic_x),
      .y_out (cordic_y),
      .z_out (cordic_z)
   );

   ocu_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a_in  (mul_a),
      .b_in  (mul_b),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_out_pos_x      = rsp_pos_ff[0];
   assign rsp_out_pos_y      = rsp_pos_ff[1];
   assign rsp_out_pos_z      = rsp_pos_ff[2];
   assign rsp_out_focus_x    = rsp_foc_ff[0];
   assign rsp_out_focus_y    = rsp_foc_ff[1];
   assign rsp_out_focus_z    = rsp_foc_ff[2];
   assign rsp_out_fov        = rsp_fov_ff;
   assign rsp_passed_through = rsp_pass_ff;

   a_units_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(cordic_done && mul_done))
      else $error("cordic and multiplier finished together");

   a_recap_needs_capture: assert property (@(posedge clock) disable iff (reset)
      recap_ff |-> captured_ff)
      else $error("recapture pending without capture");

   a_disabled_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && !enable_ff) |=> !captured_ff)
      else $error("disabled beat left camera captured");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ocu_pkg::ST_DONE))
      else $error("response raised outside done state");

endmodule

[rtl/ocu_mul.sv]
module ocu_mul (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   input  logic signed [ocu_pkg::MUL_W-1:0]        a_in,
   input  logic signed [ocu_pkg::MUL_W-1:0]        b_in,
   output logic                                    done,
   output logic signed [2*ocu_pkg::MUL_W-1:0]      prod
);

   logic [2*ocu_pkg::MUL_W-1:0]    mcand_ff;
   logic [ocu_pkg::MUL_W-1:0]      mplier_ff;
   logic [2*ocu_pkg::MUL_W-1:0]    acc_ff;
   logic                           neg_ff;
   logic                           busy_ff;
   logic                           done_ff;
   logic [ocu_pkg::MUL_CNT_W-1:0]  cnt_ff;
   logic [ocu_pkg::MUL_W-1:0]      a_mag;
   logic [ocu_pkg::MUL_W-1:0]      b_mag;
   logic [2*ocu_pkg::MUL_W-1:0]    partial;

   assign a_mag = a_in[ocu_pkg::MUL_W-1] ? (~$unsigned(a_in)) + 1'b1 : $unsigned(a_in);
   assign b_mag = b_in[ocu_pkg::MUL_W-1] ? (~$unsigned(b_in)) + 1'b1 : $unsigned(b_in);

   // one 4-bit digit of the multiplier per cycle
   assign partial = mcand_ff * {{(2*ocu_pkg::MUL_W-ocu_pkg::MUL_DIGIT){1'b0}},
                                mplier_ff[ocu_pkg::MUL_DIGIT-1:0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == ocu_pkg::MUL_CNT_W'(ocu_pkg::MUL_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         mcand_ff  <= {{ocu_pkg::MUL_W{1'b0}}, a_mag};
         mplier_ff <= b_mag;
         acc_ff    <= '0;
         neg_ff    <= a_in[ocu_pkg::MUL_W-1] ^ b_in[ocu_pkg::MUL_W-1];
      end else if (busy_ff) begin
         acc_ff    <= acc_ff + partial;
         mcand_ff  <= mcand_ff << ocu_pkg::MUL_DIGIT;
         mplier_ff <= mplier_ff >> ocu_pkg::MUL_DIGIT;
      end
   end

   assign done = done_ff;
   assign prod = neg_ff ? $signed((~acc_ff) + 1'b1) : $signed(acc_ff);

endmodule

[rtl/ocu_cordic.sv]
module ocu_cordic (
   input  logic                                  clock,
   input  logic                                  reset,
   input  ocu_pkg::cordic_cmd_type               cmd,
   input  logic signed [ocu_pkg::CORDIC_W-1:0]   x_in,
   input  logic signed [ocu_pkg::CORDIC_W-1:0]   y_in,
   input  logic signed [ocu_pkg::ANGLE_W-1:0]    z_in,
   output logic                                  done,
   output logic signed [ocu_pkg::CORDIC_W-1:0]   x_out,
   output logic signed [ocu_pkg::CORDIC_W-1:0]   y_out,
   output logic signed [ocu_pkg::ANGLE_W-1:0]    z_out
);

   logic signed [ocu_pkg::CORDIC_W-1:0] x_ff;
   logic signed [ocu_pkg::CORDIC_W-1:0] y_ff;
   logic signed [ocu_pkg::ANGLE_W-1:0]  z_ff;
   logic [ocu_pkg::ITER_W-1:0]          iter_ff;
   logic                                busy_ff;
   logic                                vec_ff;
   logic                                done_ff;
   logic                                sigma_pos;
   logic signed [ocu_pkg::CORDIC_W-1:0] xs;
   logic signed [ocu_pkg::CORDIC_W-1:0] ys;
   logic signed [ocu_pkg::ANGLE_W-1:0]  ang;

   // vectoring drives y to zero, rotation drives z to zero
   assign sigma_pos = vec_ff ? y_ff[ocu_pkg::CORDIC_W-1] : !z_ff[ocu_pkg::ANGLE_W-1];
   assign xs  = x_ff >>> iter_ff;
   assign ys  = y_ff >>> iter_ff;
   assign ang = ocu_pkg::atan_q30(5'(iter_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         iter_ff <= '0;
         vec_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            busy_ff <= 1'b1;
            iter_ff <= '0;
            vec_ff  <= cmd.vectoring;
         end else if (busy_ff) begin
            iter_ff <= iter_ff + 1'b1;
            if (iter_ff == ocu_pkg::ITER_W'(ocu_pkg::CORDIC_ITERATIONS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         if (cmd.vectoring && x_in[ocu_pkg::CORDIC_W-1]) begin
            // left half plane: turn by pi first
            x_ff <= -x_in;
            y_ff <= -y_in;
            z_ff <= y_in[ocu_pkg::CORDIC_W-1] ? -ocu_pkg::PI_Q30 : ocu_pkg::PI_Q30;
         end else begin
            x_ff <= x_in;
            y_ff <= y_in;
            z_ff <= cmd.vectoring ? '0 : z_in;
         end
      end else if (busy_ff) begin
         x_ff <= sigma_pos ? x_ff - ys : x_ff + ys;
         y_ff <= sigma_pos ? y_ff + xs : y_ff - xs;
         z_ff <= sigma_pos ? z_ff - ang : z_ff + ang;
      end
   end

   assign done  = done_ff;
   assign x_out = x_ff;
   assign y_out = y_ff;
   assign z_out = z_ff;

endmodule
